// ===== rtl/dpd_pkg.sv =====
package dpd_pkg;

	// special characters of the framing
	localparam logic [7:0] CH_INTERRUPT = 8'h03;
	localparam logic [7:0] CH_START     = 8'h24;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// result event codes
	typedef enum logic [1:0] {
		EV_PAYLOAD   = 2'd0,
		EV_GOOD      = 2'd1,
		EV_BAD       = 2'd2,
		EV_INTERRUPT = 2'd3
	} event_t;

	// framing phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_CHK1    = 4'b0100,
		PH_CHK2    = 4'b1000
	} phase_t;

	// hex digit decode result
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// one result word from the framer to the output register
	typedef struct packed {
		logic       vld;
		event_t     ev;
		logic [7:0] data;
	} res_t;

	// whitespace as strtoul skips it
	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	// hex digit value with a flag for a valid digit
	function automatic hex_t hex_val(logic [7:0] c);
		hex_t   h;
		logic [7:0] d;
		h.ok  = 1'b0;
		h.val = 4'd0;
		d     = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			d  = c - 8'h30;
			h.ok = 1'b1;
		end else if (c inside {[8'h61:8'h66]}) begin
			d  = c - 8'h57;
			h.ok = 1'b1;
		end else if (c inside {[8'h41:8'h46]}) begin
			d  = c - 8'h37;
			h.ok = 1'b1;
		end
		h.val = d[3:0];
		return h;
	endfunction

endpackage

// ===== rtl/debug_packet_deframer.sv =====
// debug_packet_deframer
// Splits a received byte stream into remote-debug packets of the form
// $payload#hh. Input channel: in_valid/in_ready with in_byte, one byte per
// word. Output channel: out_valid/out_ready with event_res and payload_byte.
// Each accepted byte gives zero or one output word: a payload byte (0), a
// packet verdict good (1) or bad (2) once the second checksum character
// arrives, or an interrupt (3) for byte 0x03 at any point.
// A byte accepted on the input passes the input register, then the output
// register, before its word shows on the output.
// Throughput: one byte per cycle while the output is not stalled; the state
// update and the 8-bit sum both sit between the input and output registers.
// Stall: while out_ready is low the output register holds its word and the
// input register can still take one more byte; bytes that give no word keep
// flowing. in_ready follows out_ready combinationally.
// Reset (arst_n low): both registers empty, framing idle, sum cleared.
// Payload bytes are passed before the verdict, so a consumer must buffer
// them until the good or bad event.
module debug_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [7:0] payload_byte
);

	dpd_pkg::res_t res;
	logic          res_space;
	logic          out_valid_q;
	logic [1:0]    event_q;
	logic [7:0]    data_q;

	dpd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.res_space (res_space),
		.res       (res)
	);

	// output register accepts a word when empty or being drained
	assign res_space = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_space) begin
			out_valid_q <= res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_space && res.vld) begin
			event_q <= res.ev;
			data_q  <= res.data;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = event_q;
	assign payload_byte = data_q;

endmodule

// ===== rtl/dpd_check.sv =====
module dpd_check (
	input  logic [7:0] c0,
	input  logic [7:0] c1,
	input  logic [7:0] sum,
	output logic       good
);

	dpd_pkg::hex_t h0;
	dpd_pkg::hex_t h1;
	logic [7:0]    d1;
	logic [7:0]    value;

	assign h0 = dpd_pkg::hex_val(c0);
	assign h1 = dpd_pkg::hex_val(c1);
	assign d1 = h1.ok ? {4'd0, h1.val} : 8'd0;

	// two-character strtoul in base 16, reduced to a byte
	always_comb begin
		if (dpd_pkg::is_space(c0)) begin
			value = d1;
		end else if (c0 == dpd_pkg::CH_MINUS) begin
			value = 8'd0 - d1;
		end else if (c0 == dpd_pkg::CH_PLUS) begin
			value = d1;
		end else if (h0.ok) begin
			value = h1.ok ? {h0.val, h1.val} : {4'd0, h0.val};
		end else begin
			value = 8'd0;
		end
	end

	assign good = (value == sum);

endmodule

// ===== rtl/dpd_frame.sv =====
module dpd_frame (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          res_space,
	output dpd_pkg::res_t res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	dpd_pkg::phase_t   phase_q;
	dpd_pkg::phase_t   phase_d;
	logic [7:0]        sum_q;
	logic [7:0]        sum_d;
	logic [7:0]        first_q;
	logic [7:0]        first_d;
	logic              adv;
	logic              good;

	dpd_check u_check (
		.c0   (first_q),
		.c1   (byte_s1),
		.sum  (sum_q),
		.good (good)
	);

	// input stage advances when its result, if any, has room
	assign adv      = valid_s1 && (!res.vld || res_space);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// byte classification and next framing state
	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		first_d  = first_q;
		res.vld  = 1'b0;
		res.ev   = dpd_pkg::EV_PAYLOAD;
		res.data = 8'd0;
		if (byte_s1 == dpd_pkg::CH_INTERRUPT) begin
			res.vld = valid_s1;
			res.ev  = dpd_pkg::EV_INTERRUPT;
		end else if (byte_s1 == dpd_pkg::CH_START) begin
			phase_d = dpd_pkg::PH_PAYLOAD;
			sum_d   = 8'd0;
		end else begin
			case (phase_q)
				dpd_pkg::PH_PAYLOAD: begin
					if (byte_s1 == dpd_pkg::CH_HASH) begin
						phase_d = dpd_pkg::PH_CHK1;
					end else begin
						sum_d    = sum_q + byte_s1;
						res.vld  = valid_s1;
						res.ev   = dpd_pkg::EV_PAYLOAD;
						res.data = byte_s1;
					end
				end
				dpd_pkg::PH_CHK1: begin
					first_d = byte_s1;
					phase_d = dpd_pkg::PH_CHK2;
				end
				dpd_pkg::PH_CHK2: begin
					res.vld = valid_s1;
					res.ev  = good ? dpd_pkg::EV_GOOD : dpd_pkg::EV_BAD;
					phase_d = dpd_pkg::PH_IDLE;
					sum_d   = 8'd0;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dpd_pkg::PH_IDLE;
			sum_q   <= 8'd0;
			first_q <= 8'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			first_q <= first_d;
		end
	end

	// interrupt leaves the framing state alone
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && byte_s1 == dpd_pkg::CH_INTERRUPT
		|=> phase_q == $past(phase_q) && sum_q == $past(sum_q))
		else $error("interrupt changed framing state");

	// start byte opens a packet with a clear sum
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && byte_s1 == dpd_pkg::CH_START
		|=> phase_q == dpd_pkg::PH_PAYLOAD && sum_q == 8'd0)
		else $error("start byte did not open a packet");

	// verdict closes the packet
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.vld && (res.ev == dpd_pkg::EV_GOOD || res.ev == dpd_pkg::EV_BAD)
		|=> phase_q == dpd_pkg::PH_IDLE && sum_q == 8'd0)
		else $error("verdict did not close the packet");

	// a verdict only comes out of the second checksum phase
	assert property (@(posedge clk) disable iff (!arst_n)
		res.vld && (res.ev == dpd_pkg::EV_GOOD || res.ev == dpd_pkg::EV_BAD)
		|-> phase_q == dpd_pkg::PH_CHK2)
		else $error("verdict outside checksum phase");

endmodule
